// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/wdf_pkg.sv =====
// ----------------------------------------------------------------------------
// wdf_pkg
// types and constants of the windowed duplicate filter
// ----------------------------------------------------------------------------
package wdf_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam logic [31:0] WINDOW_RESET = 32'd30000;

    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] key_hash;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic       is_duplicate;
        logic [3:0] slot_used;
    } t_out_item;

    // per-slot compare results
    typedef struct packed {
        logic hit;
        logic older;
    } t_slot_flags;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

endpackage

// ===== rtl/core/wdf_slot_cmp.sv =====
// ----------------------------------------------------------------------------
// wdf_slot_cmp
// shared compare unit: match and age test, oldest-time test for one slot
// ----------------------------------------------------------------------------
module wdf_slot_cmp (
    input  logic                 i_slot_valid,
    input  logic [31:0]          i_slot_hash,
    input  logic [31:0]          i_slot_time,
    input  logic [31:0]          i_key,
    input  logic [31:0]          i_now,
    input  logic [31:0]          i_window,
    input  logic [31:0]          i_best_time,
    output wdf_pkg::t_slot_flags o_flags
);

    logic [31:0] age;

    // modulo 2^32 age
    assign age = i_now - i_slot_time;

    assign o_flags.hit   = i_slot_valid && (i_slot_hash == i_key) && (age < i_window);
    // plain unsigned compare, no wraparound handling
    assign o_flags.older = i_slot_time < i_best_time;

endmodule

// ===== rtl/core/windowed_duplicate_filter.sv =====
// ----------------------------------------------------------------------------
// windowed_duplicate_filter
// time-window dedup cache: checks a hash against recent entries or records it
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  item      in         i_start && !o_busy           i_item  (op, key_hash, time_ms)
//  result    out        o_res_valid, one-cycle pulse o_res   (is_duplicate, slot_used)
//  config    in         i_cfg_valid && o_cfg_ready   i_cfg_data (window_ms)
//
//  an item goes through the scan, reading one slot per cycle from the slot memory,
//  and then through the drain and finish states up to the result strobe
//  o_busy is high from the cycle after accept until the result strobe
//  result strobe lasts one cycle; the receiver cannot stall it
//  reset clears valid marks and the state machine at once; no clearing pass
//  config writes are always taken (o_cfg_ready tied high)
// ----------------------------------------------------------------------------
module windowed_duplicate_filter #(
    parameter int SLOTS = wdf_pkg::SLOTS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  wdf_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_res_valid,
    output wdf_pkg::t_out_item o_res,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    output logic               o_cfg_ready
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // state machine
    wdf_pkg::t_state r_state, n_state;

    // latched item and window register
    wdf_pkg::t_in_item r_item;
    logic [31:0]       r_window;

    // slot storage: hash and time in memory, valid marks in flops
    logic [31:0]      r_hash_mem [SLOTS];
    logic [31:0]      r_time_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;

    // scan read address and the registered read stage
    logic [IDX_W-1:0] r_idx;
    logic             r_pipe_vld;
    logic [IDX_W-1:0] r_pipe_idx;
    logic [31:0]      r_rd_hash;
    logic [31:0]      r_rd_time;
    logic             r_rd_valid;

    // scan accumulators
    logic             r_dup;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_v0;
    logic [IDX_W-1:0] r_best_idx;
    logic [31:0]      r_best_time;

    // result register
    logic               r_res_valid;
    wdf_pkg::t_out_item r_res;

    wdf_pkg::t_slot_flags flags;
    logic [IDX_W-1:0]     n_slot;
    logic                 accept;
    logic                 is_record;

    assign accept    = i_start && (r_state == wdf_pkg::ST_IDLE);
    assign is_record = (r_item.op == wdf_pkg::OP_RECORD);

    assign o_busy      = (r_state != wdf_pkg::ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    // the one compare unit, fed by the slot under evaluation
    wdf_slot_cmp u_cmp (
        .i_slot_valid (r_rd_valid),
        .i_slot_hash  (r_rd_hash),
        .i_slot_time  (r_rd_time),
        .i_key        (r_item.key_hash),
        .i_now        (r_item.time_ms),
        .i_window     (r_window),
        .i_best_time  (r_best_time),
        .o_flags      (flags)
    );

    // replacement choice: first free from slot 1 up, then slot 0, then oldest
    always_comb begin
        if (r_free_found) begin
            n_slot = r_free_idx;
        end else if (!r_v0) begin
            n_slot = '0;
        end else begin
            n_slot = r_best_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wdf_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = wdf_pkg::ST_SCAN;
                end
            end
            wdf_pkg::ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = wdf_pkg::ST_DRAIN;
                end
            end
            wdf_pkg::ST_DRAIN: begin
                n_state = wdf_pkg::ST_FINISH;
            end
            wdf_pkg::ST_FINISH: begin
                n_state = wdf_pkg::ST_IDLE;
            end
            default: begin
                n_state = wdf_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wdf_pkg::ST_IDLE;
            r_window    <= wdf_pkg::WINDOW_RESET;
            r_valid     <= '0;
            r_pipe_vld  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pipe_vld  <= (r_state == wdf_pkg::ST_SCAN);
            r_res_valid <= (r_state == wdf_pkg::ST_FINISH);
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            if ((r_state == wdf_pkg::ST_FINISH) && is_record) begin
                r_valid[n_slot] <= 1'b1;
            end
        end
    end

    // item latch, scan address, read stage and accumulators
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
            r_idx  <= '0;
        end else if (r_state == wdf_pkg::ST_SCAN) begin
            r_idx <= r_idx + 1'b1;
        end

        // registered read of the slot under scan
        r_rd_hash  <= r_hash_mem[r_idx];
        r_rd_time  <= r_time_mem[r_idx];
        r_rd_valid <= r_valid[r_idx];
        r_pipe_idx <= r_idx;

        if (r_pipe_vld) begin
            if (r_pipe_idx == '0) begin
                // first slot seeds the running values
                r_dup        <= flags.hit;
                r_free_found <= 1'b0;
                r_free_idx   <= '0;
                r_v0         <= r_rd_valid;
                r_best_idx   <= '0;
                r_best_time  <= r_rd_time;
            end else begin
                r_dup <= r_dup | flags.hit;
                if (!r_rd_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_pipe_idx;
                end
                // strict compare keeps the lowest index on ties
                if (flags.older) begin
                    r_best_idx  <= r_pipe_idx;
                    r_best_time <= r_rd_time;
                end
            end
        end

        if (r_state == wdf_pkg::ST_FINISH) begin
            if (is_record) begin
                r_res.is_duplicate <= 1'b0;
                r_res.slot_used    <= 4'(n_slot);
            end else begin
                r_res.is_duplicate <= r_dup;
                r_res.slot_used    <= 4'd0;
            end
        end
    end

    // slot memory write at the end of a record
    always_ff @(posedge i_clk) begin
        if ((r_state == wdf_pkg::ST_FINISH) && is_record) begin
            r_hash_mem[n_slot] <= r_item.key_hash;
            r_time_mem[n_slot] <= r_item.time_ms;
        end
    end

endmodule

// ===== rtl/core/wdf_checker.sv =====
// ----------------------------------------------------------------------------
// wdf_checker
// port-level checks of the windowed duplicate filter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wdf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_res_valid,
    input wdf_pkg::t_out_item o_res
);

    // an accepted item makes the block busy
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)

    // a result shows exactly when busy drops
    `ASSERT_IMPLY(a_res_at_fall, i_clk, i_rst_n, o_res_valid, $fell(o_busy))
    `ASSERT_IMPLY(a_fall_has_res, i_clk, i_rst_n, $fell(o_busy), o_res_valid)

    // a result never flags a duplicate and names a nonzero slot at once
    `ASSERT_IMPLY(a_res_kind, i_clk, i_rst_n, o_res_valid,
        !(o_res.is_duplicate && (o_res.slot_used != 4'd0)))

endmodule

bind windowed_duplicate_filter wdf_checker u_wdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ===== test/tb_windowed_duplicate_filter.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_duplicate_filter
// self-checking bench: directed and random check/record traffic against a local table model
// ----------------------------------------------------------------------------
//  a driver block feeds items from a pending queue in bursts with random gaps
//  a monitor block predicts each accepted item and compares every result strobe
//  window_ms is rewritten between phases while the filter is idle
// ----------------------------------------------------------------------------
module tb_windowed_duplicate_filter;

    localparam int NSLOTS         = wdf_pkg::SLOTS_DEFAULT;
    localparam int NPHASES        = 7;
    localparam int RAND_PER_PHASE = 270;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int REPORT_MAX     = 10;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    wdf_pkg::t_in_item  item      = '0;
    logic               cfg_valid = 1'b0;
    logic [31:0]        cfg_data  = '0;
    logic               busy;
    logic               res_valid;
    wdf_pkg::t_out_item res;
    logic               cfg_ready;

    // local copy of the filter table and its window
    logic [31:0]       tbl_hash [NSLOTS];
    logic [31:0]       tbl_time [NSLOTS];
    logic [NSLOTS-1:0] tbl_valid = '0;
    logic [31:0]       win_ms    = wdf_pkg::WINDOW_RESET;

    wdf_pkg::t_in_item  pending [$];
    wdf_pkg::t_out_item expected_res [$];

    logic [31:0] now_ms = '0;
    int cycle_count = 0;
    int mismatches  = 0;
    int n_check     = 0;
    int n_dup       = 0;
    int n_record    = 0;
    int n_evict     = 0;
    int n_windows   = 0;
    int burst_left  = 1;
    int gap_left    = 0;

    windowed_duplicate_filter #(
        .SLOTS(NSLOTS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_start    (start),
        .i_item     (item),
        .o_busy     (busy),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_cfg_valid(cfg_valid),
        .i_cfg_data (cfg_data),
        .o_cfg_ready(cfg_ready)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic wdf_pkg::t_in_item make_item(input logic op, input logic [31:0] key,
                                                    input logic [31:0] t);
        wdf_pkg::t_in_item it;
        it.op       = op;
        it.key_hash = key;
        it.time_ms  = t;
        return it;
    endfunction

    // applies one item to the local table and returns the result it must give
    function automatic wdf_pkg::t_out_item filter_step(input wdf_pkg::t_in_item it);
        wdf_pkg::t_out_item r;
        logic [31:0]        age;
        int                 slot;
        r = '0;
        if (it.op == wdf_pkg::OP_CHECK) begin
            n_check++;
            for (int i = 0; i < NSLOTS; i++) begin
                age = it.time_ms - tbl_time[i];
                if (tbl_valid[i] && tbl_hash[i] == it.key_hash && age < win_ms)
                    r.is_duplicate = 1'b1;
            end
            if (r.is_duplicate)
                n_dup++;
        end else begin
            n_record++;
            // first free slot from 1 upward, then slot 0
            slot = -1;
            for (int i = 1; i < NSLOTS; i++)
                if (slot < 0 && !tbl_valid[i])
                    slot = i;
            if (slot < 0 && !tbl_valid[0])
                slot = 0;
            // table full: oldest stored time as a plain number, lowest index on ties
            if (slot < 0) begin
                n_evict++;
                slot = 0;
                for (int i = 1; i < NSLOTS; i++)
                    if (tbl_time[i] < tbl_time[slot])
                        slot = i;
            end
            tbl_hash[slot]  = it.key_hash;
            tbl_time[slot]  = it.time_ms;
            tbl_valid[slot] = 1'b1;
            r.slot_used     = 4'(slot);
        end
        return r;
    endfunction

    // driver: bursts of items with random gaps, holds an item until it is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending.size() > 0) begin
                item  <= pending.pop_front();
                start <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare strobes first, then predict the item taken at this edge
    always @(posedge clk) begin
        wdf_pkg::t_out_item want;
        cycle_count++;
        if (rst_n) begin
            if (res_valid) begin
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("cycle %0d: result with none expected: dup=%0d slot=%0d",
                                 cycle_count, res.is_duplicate, res.slot_used);
                end else begin
                    want = expected_res.pop_front();
                    if (res.is_duplicate !== want.is_duplicate ||
                        res.slot_used !== want.slot_used) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("cycle %0d: expected dup=%0d slot=%0d, got dup=%0d slot=%0d",
                                     cycle_count, want.is_duplicate, want.slot_used,
                                     res.is_duplicate, res.slot_used);
                    end
                end
            end
            if (start && !busy)
                expected_res.push_back(filter_step(item));
            if (cfg_valid && cfg_ready)
                win_ms = cfg_data;
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending.size() != 0 || start || expected_res.size() != 0);
    endtask

    task automatic write_window(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        n_windows++;
    endtask

    // random traffic around a running clock, keys mostly from a small pool
    task automatic queue_random_phase(input logic [31:0] w, input int count);
        logic [31:0] pool [6];
        logic [31:0] span;
        logic [31:0] k;
        logic [31:0] t;
        logic [31:0] last_key;
        logic [31:0] last_time;
        logic        op;
        int          r;
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < 6; i++)
            pool[i] = $urandom;
        span      = (w < 16) ? 32'd16 : w;
        last_key  = pool[2];
        last_time = now_ms;
        @(negedge clk);
        repeat (count) begin
            op = ($urandom_range(0, 99) < 45) ? wdf_pkg::OP_RECORD : wdf_pkg::OP_CHECK;
            k  = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, 5)];
            r  = $urandom_range(0, 99);
            if (r < 10) begin
                t = $urandom;
            end else if (r < 20) begin
                // behind the running clock, so stored entries look future
                t = now_ms - $urandom_range(0, span >> 3);
            end else begin
                now_ms += $urandom_range(0, (span >> 3) + 1);
                t = now_ms;
            end
            // probe the age right at and just below the window edge
            if (op == wdf_pkg::OP_CHECK && $urandom_range(0, 6) == 0) begin
                k = last_key;
                t = last_time + w - $urandom_range(0, 1);
            end
            if (op == wdf_pkg::OP_RECORD) begin
                last_key  = k;
                last_time = t;
            end
            pending.push_back(make_item(op, k, t));
        end
    endtask

    initial begin
        logic [31:0] windows [NPHASES];
        windows[0] = 32'd0;
        windows[1] = 32'd1;
        windows[2] = 32'hFFFF_FFFF;
        windows[3] = 32'h8000_0000;
        windows[4] = $urandom_range(2, 5000);
        windows[5] = $urandom;
        windows[6] = wdf_pkg::WINDOW_RESET;

        // directed part at the reset window
        pending.push_back(make_item(wdf_pkg::OP_CHECK,  32'h0, 32'd0));     // empty table
        pending.push_back(make_item(wdf_pkg::OP_CHECK,  32'h0, 32'd5));
        pending.push_back(make_item(wdf_pkg::OP_RECORD, 32'h0, 32'd0));
        pending.push_back(make_item(wdf_pkg::OP_CHECK,  32'h0, 32'd0));     // age zero
        pending.push_back(make_item(wdf_pkg::OP_CHECK,  32'h0, 32'd29999)); // just inside
        pending.push_back(make_item(wdf_pkg::OP_CHECK,  32'h0, 32'd30000)); // just outside
        pending.push_back(make_item(wdf_pkg::OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // age across wrap
        pending.push_back(make_item(wdf_pkg::OP_CHECK,  32'hFFFF_FFFF, 32'd5));
        // future entry
        pending.push_back(make_item(wdf_pkg::OP_CHECK,  32'hFFFF_FFFF, 32'hFFFF_FFFE));
        // same hash, new slot
        pending.push_back(make_item(wdf_pkg::OP_RECORD, 32'h0, 32'd10));
        repeat (13) // fill, equal times
            pending.push_back(make_item(wdf_pkg::OP_RECORD, $urandom, 32'd0));
        // eviction on a tie
        pending.push_back(make_item(wdf_pkg::OP_RECORD, 32'hA5A5_A5A5, 32'd7));
        pending.push_back(make_item(wdf_pkg::OP_CHECK,  32'hA5A5_A5A5, 32'd7));

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        for (int ph = 0; ph < NPHASES; ph++) begin
            write_window(windows[ph]);
            now_ms = (ph % 2) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3000);
            queue_random_phase(windows[ph], RAND_PER_PHASE);
            wait_idle();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
        if (expected_res.size() != 0) begin
            $display("%0d results never arrived", expected_res.size());
            mismatches += expected_res.size();
        end

        $display("ran %0d checks (%0d duplicates) and %0d records (%0d evictions)",
                 n_check, n_dup, n_record, n_evict);
        $display("over %0d window settings in %0d cycles, %0d mismatches",
                 n_windows + 1, cycle_count, mismatches);
        if (mismatches == 0) begin
            $display("PASS windowed_duplicate_filter");
        end else begin
            $display("FAIL windowed_duplicate_filter");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL windowed_duplicate_filter");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/wdf_pkg.sv
rtl/core/wdf_slot_cmp.sv
rtl/core/windowed_duplicate_filter.sv
rtl/core/wdf_checker.sv
test/tb_windowed_duplicate_filter.sv
